FILE: design/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types, fixed-point constants and the CORDIC arctangent table for
// the quaternion point rotator.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int unsigned CoordW = 32;   // Q16.16 coordinate
  localparam int unsigned AngleW = 16;   // Q3.12 angle
  localparam int unsigned QuatW  = 32;   // Q2.30 quaternion component
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAngleX  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAngleY  = 3'd4;

  // CORDIC sizing: x/y carry Q.30 values with headroom, z holds a half angle
  localparam int unsigned CordXyW    = 34;
  localparam int unsigned CordZW     = 36;
  localparam int unsigned CordSteps  = 30;
  localparam int unsigned CordCntW   = 5;

  localparam logic signed [CordXyW-1:0] CordGain  = 34'sd652032874;
  localparam logic signed [CordZW-1:0]  PiQ30     = 36'sd3373259426;
  localparam logic signed [CordZW-1:0]  HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [QuatW-1:0]   QuatOne   = 32'sd1073741824;

  typedef struct packed {
    logic signed [QuatW-1:0] w;
    logic signed [QuatW-1:0] x;
    logic signed [QuatW-1:0] y;
    logic signed [QuatW-1:0] z;
  } quat_t;

  // atan(2^-i) in Q.30; past step 10 it equals 2^(30-i)
  function automatic logic signed [CordZW-1:0] atan_step(input logic [CordCntW-1:0] i);
    unique case (i)
      5'd0:    atan_step = 36'sd843314857;
      5'd1:    atan_step = 36'sd497837829;
      5'd2:    atan_step = 36'sd263043837;
      5'd3:    atan_step = 36'sd133525159;
      5'd4:    atan_step = 36'sd67021688;
      5'd5:    atan_step = 36'sd33543516;
      5'd6:    atan_step = 36'sd16775851;
      5'd7:    atan_step = 36'sd8388437;
      5'd8:    atan_step = 36'sd4194283;
      5'd9:    atan_step = 36'sd2097149;
      5'd10:   atan_step = 36'sd1048576;
      default: atan_step = 36'sd1 <<< (5'd30 - i);
    endcase
  endfunction

endpackage

FILE: design/qpr_cordic.sv
// ----------------------------------------------------------------------------
// qpr_cordic
// Iterative rotation-mode CORDIC: sine and cosine of half a Q3.12 angle,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module qpr_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [qpr_pkg::AngleW-1:0]   angle_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic signed [qpr_pkg::QuatW-1:0]    cos_o,
  output logic signed [qpr_pkg::QuatW-1:0]    sin_o
);
  import qpr_pkg::*;

  logic signed [CordXyW-1:0]  x_q, x_d, y_q, y_d, xs, ys;
  logic signed [CordZW-1:0]   z_q, z_d, h, atn;
  logic [CordCntW-1:0]        cnt_q, cnt_d;
  logic                       run_q, run_d, done_q, done_d, neg_q, neg_d;
  logic signed [CordXyW-1:0]  cos_full, sin_full;

  // half angle in Q.30 is angle * 2^17
  assign h   = {{(CordZW-AngleW-17){angle_i[AngleW-1]}}, angle_i, 17'd0};
  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign atn = atan_step(cnt_q);

  // start loads a range-reduced angle, then one step per cycle
  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q;
    cnt_d = cnt_q; run_d = run_q; neg_d = neg_q; done_d = 1'b0;
    if (start_i) begin
      x_d = CordGain; y_d = '0; cnt_d = '0; run_d = 1'b1;
      if (h > HalfPiQ30) begin
        z_d = h - PiQ30; neg_d = 1'b1;
      end else if (h < -HalfPiQ30) begin
        z_d = h + PiQ30; neg_d = 1'b1;
      end else begin
        z_d = h; neg_d = 1'b0;
      end
    end else if (run_q) begin
      if (!z_q[CordZW-1]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - atn;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + atn;
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == CordCntW'(CordSteps - 1)) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; neg_q <= 1'b0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d; neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign cos_full = neg_q ? -x_q : x_q;
  assign sin_full = neg_q ? -y_q : y_q;
  assign cos_o  = cos_full[QuatW-1:0];
  assign sin_o  = sin_full[QuatW-1:0];
  assign busy_o = run_q;
  assign done_o = done_q;

endmodule

FILE: design/qpr_quat_gen.sv
// ----------------------------------------------------------------------------
// qpr_quat_gen
// Builds q = qx * qy from the two half-angle CORDICs and holds it.
// ----------------------------------------------------------------------------
module qpr_quat_gen (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [qpr_pkg::AngleW-1:0]  angle_x_i,
  input  logic signed [qpr_pkg::AngleW-1:0]  angle_y_i,
  output logic                               busy_o,
  output qpr_pkg::quat_t                     quat_o
);
  import qpr_pkg::*;

  localparam int unsigned ProdW = 2 * QuatW;
  localparam logic signed [ProdW-1:0] Rnd = 64'sd536870912;

  logic signed [QuatW-1:0] cx, sx, cy, sy;
  logic busy_x, busy_y, done_x, done_y;
  logic signed [ProdW-1:0] p_q [4];
  logic pv_q;
  quat_t quat_q;

  qpr_cordic u_cordic_x (
    .clk_i, .rst_ni, .start_i, .angle_i(angle_x_i),
    .busy_o(busy_x), .done_o(done_x), .cos_o(cx), .sin_o(sx)
  );

  qpr_cordic u_cordic_y (
    .clk_i, .rst_ni, .start_i, .angle_i(angle_y_i),
    .busy_o(busy_y), .done_o(done_y), .cos_o(cy), .sin_o(sy)
  );

  // round a Q.60 product to Q.30 and saturate to 32 bits
  function automatic logic signed [QuatW-1:0] rnd_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    logic signed [ProdW-31:0] r;
    t = p + Rnd;
    r = t[ProdW-1:30];
    if (r > 34'sd2147483647)       rnd_sat = 32'sh7fffffff;
    else if (r < -34'sd2147483648) rnd_sat = 32'sh80000000;
    else                           rnd_sat = r[QuatW-1:0];
  endfunction

  // product stage
  always_ff @(posedge clk_i) begin
    if (done_x) begin
      p_q[0] <= cx * cy;
      p_q[1] <= sx * cy;
      p_q[2] <= cx * sy;
      p_q[3] <= sx * sy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      quat_q <= '{w: QuatOne, x: '0, y: '0, z: '0};
    end else begin
      pv_q <= done_x && !start_i;
      if (pv_q) begin
        quat_q <= '{w: rnd_sat(p_q[0]), x: rnd_sat(p_q[1]),
                    y: rnd_sat(p_q[2]), z: rnd_sat(p_q[3])};
      end
    end
  end

  assign busy_o = busy_x | busy_y | done_x | done_y | pv_q;
  assign quat_o = quat_q;

endmodule

FILE: design/qpr_rot_pipe.sv
// ----------------------------------------------------------------------------
// qpr_rot_pipe
// Six-stage rotation pipeline: translate, q*p products, sums,
// (t)*conj(q) products, sums, translate back and saturate.
// ----------------------------------------------------------------------------
module qpr_rot_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  x_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  y_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  z_i,
  input  qpr_pkg::quat_t                     quat_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  cx_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  cy_i,
  input  logic signed [qpr_pkg::CoordW-1:0]  cz_i,
  output logic                               valid_o,
  output logic signed [qpr_pkg::CoordW-1:0]  x_o,
  output logic signed [qpr_pkg::CoordW-1:0]  y_o,
  output logic signed [qpr_pkg::CoordW-1:0]  z_o
);
  import qpr_pkg::*;

  localparam int unsigned DW  = CoordW + 1;       // exact difference
  localparam int unsigned P1W = QuatW + DW;       // first products
  localparam int unsigned R1W = P1W - 30;         // rounded
  localparam int unsigned TW  = R1W + 2;          // t sums
  localparam int unsigned P2W = QuatW + TW;
  localparam int unsigned R2W = P2W - 30;
  localparam int unsigned SW  = R2W + 2;          // r sums
  localparam int unsigned OW  = SW + 1;           // plus center

  localparam logic signed [P1W-1:0] Rnd1 = P1W'(64'sd536870912);
  localparam logic signed [P2W-1:0] Rnd2 = P2W'(64'sd536870912);
  localparam logic signed [OW-1:0]  MaxO = OW'(64'sd2147483647);
  localparam logic signed [OW-1:0]  MinO = -OW'(64'sd2147483648);

  logic [5:0] v_q;

  logic signed [DW-1:0]  dx_q, dy_q, dz_q;
  logic signed [P1W-1:0] p1_q [12];
  logic signed [P1W-1:0] p1r  [12];
  logic signed [R1W-1:0] r1   [12];
  logic signed [TW-1:0]  tw_q, tx_q, ty_q, tz_q;
  logic signed [P2W-1:0] p2_q [12];
  logic signed [P2W-1:0] p2r  [12];
  logic signed [R2W-1:0] r2   [12];
  logic signed [SW-1:0]  rx_q, ry_q, rz_q;
  logic signed [OW-1:0]  ox, oy, oz;
  logic signed [CoordW-1:0] x_q, y_q, z_q;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [OW-1:0] v);
    if (v > MaxO)      sat = {1'b0, {(CoordW-1){1'b1}}};
    else if (v < MinO) sat = {1'b1, {(CoordW-1){1'b0}}};
    else               sat = v[CoordW-1:0];
  endfunction

  // rounding of each product before the sums
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      p1r[k] = p1_q[k] + Rnd1;
      r1[k]  = p1r[k][P1W-1:30];
      p2r[k] = p2_q[k] + Rnd2;
      r2[k]  = p2r[k][P2W-1:30];
    end
  end

  // translate back and saturate
  assign ox = OW'(rx_q) + OW'(cx_i);
  assign oy = OW'(ry_q) + OW'(cy_i);
  assign oz = OW'(rz_q) + OW'(cz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: move center to origin
      dx_q <= DW'(x_i) - DW'(cx_i);
      dy_q <= DW'(y_i) - DW'(cy_i);
      dz_q <= DW'(z_i) - DW'(cz_i);
      // stage 2: q * (0, d)
      p1_q[0]  <= quat_i.x * dx_q;  p1_q[1]  <= quat_i.y * dy_q;
      p1_q[2]  <= quat_i.z * dz_q;  p1_q[3]  <= quat_i.w * dx_q;
      p1_q[4]  <= quat_i.y * dz_q;  p1_q[5]  <= quat_i.z * dy_q;
      p1_q[6]  <= quat_i.w * dy_q;  p1_q[7]  <= quat_i.x * dz_q;
      p1_q[8]  <= quat_i.z * dx_q;  p1_q[9]  <= quat_i.w * dz_q;
      p1_q[10] <= quat_i.x * dy_q;  p1_q[11] <= quat_i.y * dx_q;
      // stage 3: t sums
      tw_q <= -TW'(r1[0]) - TW'(r1[1]) - TW'(r1[2]);
      tx_q <=  TW'(r1[3]) + TW'(r1[4]) - TW'(r1[5]);
      ty_q <=  TW'(r1[6]) - TW'(r1[7]) + TW'(r1[8]);
      tz_q <=  TW'(r1[9]) + TW'(r1[10]) - TW'(r1[11]);
      // stage 4: t * conj(q)
      p2_q[0]  <= quat_i.x * tw_q;  p2_q[1]  <= quat_i.w * tx_q;
      p2_q[2]  <= quat_i.z * ty_q;  p2_q[3]  <= quat_i.y * tz_q;
      p2_q[4]  <= quat_i.y * tw_q;  p2_q[5]  <= quat_i.z * tx_q;
      p2_q[6]  <= quat_i.w * ty_q;  p2_q[7]  <= quat_i.x * tz_q;
      p2_q[8]  <= quat_i.z * tw_q;  p2_q[9]  <= quat_i.y * tx_q;
      p2_q[10] <= quat_i.x * ty_q;  p2_q[11] <= quat_i.w * tz_q;
      // stage 5: r sums
      rx_q <= -SW'(r2[0]) + SW'(r2[1]) - SW'(r2[2]) + SW'(r2[3]);
      ry_q <= -SW'(r2[4]) + SW'(r2[5]) + SW'(r2[6]) - SW'(r2[7]);
      rz_q <= -SW'(r2[8]) - SW'(r2[9]) + SW'(r2[10]) + SW'(r2[11]);
      // stage 6: output register
      x_q <= sat(ox);
      y_q <= sat(oy);
      z_q <= sat(oz);
    end
  end

  assign valid_o = v_q[5];
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

FILE: design/quaternion_point_rotator.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotator
// Rotates Q16.16 points about a configured center by q = qx * qy.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: in_x, in_y, in_z
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: out_x, out_y, out_z
//   cfg       in   cfg_we_i (no wait)           cfg_addr_i, cfg_wdata_i
//
// One point per cycle unless the output stalls or the quaternion is being rebuilt.
// An angle write runs two 30-step CORDICs and a product stage; s_axis_tready
// is low until the new quaternion is in place. A second angle write restarts it.
// Reset leaves the identity rotation and a zero center.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module quaternion_point_rotator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [95:0]                      s_axis_tdata,  // in_x, in_y, in_z
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [95:0]                      m_axis_tdata,  // out_x, out_y, out_z
  input  logic                             cfg_we_i,
  input  logic [qpr_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [31:0]                      cfg_wdata_i
);
  import qpr_pkg::*;

  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic signed [AngleW-1:0] ax_q, ay_q, ax_n, ay_n;
  logic       start, busy, en, pipe_valid;
  quat_t      quat;
  logic signed [CoordW-1:0] ox, oy, oz;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; cz_q <= '0; ax_q <= '0; ay_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegCenterX: cx_q <= cfg_wdata_i;
        RegCenterY: cy_q <= cfg_wdata_i;
        RegCenterZ: cz_q <= cfg_wdata_i;
        RegAngleX:  ax_q <= cfg_wdata_i[AngleW-1:0];
        RegAngleY:  ay_q <= cfg_wdata_i[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // angles as they stand after this write
  assign start = cfg_we_i && (cfg_addr_i == RegAngleX || cfg_addr_i == RegAngleY);
  assign ax_n  = (cfg_addr_i == RegAngleX) ? cfg_wdata_i[AngleW-1:0] : ax_q;
  assign ay_n  = (cfg_addr_i == RegAngleY) ? cfg_wdata_i[AngleW-1:0] : ay_q;

  qpr_quat_gen u_quat_gen (
    .clk_i, .rst_ni, .start_i(start),
    .angle_x_i(ax_n), .angle_y_i(ay_n),
    .busy_o(busy), .quat_o(quat)
  );

  assign en            = !pipe_valid || m_axis_tready;
  assign s_axis_tready = en && !busy;

  qpr_rot_pipe u_rot_pipe (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s_axis_tvalid && s_axis_tready),
    .x_i(s_axis_tdata[31:0]), .y_i(s_axis_tdata[63:32]), .z_i(s_axis_tdata[95:64]),
    .quat_i(quat), .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q),
    .valid_o(pipe_valid), .x_o(ox), .y_o(oy), .z_o(oz)
  );

  assign m_axis_tvalid = pipe_valid;
  assign m_axis_tdata  = {oz, oy, ox};

  // no point enters while the quaternion is being rebuilt
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("item accepted during quaternion build");

  // an angle write starts a rebuild
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("angle write did not start a rebuild");

  // a stalled result stays presented
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result lost or changed");

endmodule

FILE: verif/qpr_checker.sv
// ----------------------------------------------------------------------------
// qpr_checker
// Watches the point streams and configuration writes of the quaternion point
// rotator. It keeps its own center, angles and rotation quaternion, works out
// the rotated point for every accepted input, and compares each output with
// the oldest expected point, coordinate by coordinate.
// ----------------------------------------------------------------------------
module qpr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,   // in_x, in_y, in_z
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [95:0]                 m_axis_tdata,   // out_x, out_y, out_z
  input  logic                        cfg_we_i,
  input  logic [qpr_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [31:0]                 cfg_wdata_i,
  output int                          err_count_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qpr_pkg::*;

  localparam longint ATAN_Q30 [11] = '{843314857, 497837829, 263043837, 133525159,
    67021688, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
  localparam longint HALF_Q30 = 64'sd536870912;

  longint center_x, center_y, center_z;
  logic signed [AngleW-1:0] ang_x, ang_y;
  longint rot_w, rot_x, rot_y, rot_z;
  logic [95:0] expected_points [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cosine and sine of half the angle, Q.30, by rotation-mode CORDIC
  task automatic half_trig(input logic signed [AngleW-1:0] ang, output longint c,
                           output longint s);
    longint z, x, y, xs, ys, step;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      step = (i < 11) ? ATAN_Q30[i] : (64'sd1 <<< (30 - i));
      if (z >= 0) begin
        x -= ys; y += xs; z -= step;
      end else begin
        x += ys; y -= xs; z += step;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // q * v / 2^30 rounded half up, exact at any width
  function automatic longint qmul(input longint q, input longint v);
    logic signed [127:0] p;
    p = 128'(q) * 128'(v) + 128'(HALF_Q30);
    return longint'(p >>> 30);
  endfunction

  task automatic rebuild_quat();
    longint cx, sx, cy, sy;
    half_trig(ang_x, cx, sx);
    half_trig(ang_y, cy, sy);
    rot_w = clamp32((cx * cy + HALF_Q30) >>> 30);
    rot_x = clamp32((sx * cy + HALF_Q30) >>> 30);
    rot_y = clamp32((cx * sy + HALF_Q30) >>> 30);
    rot_z = clamp32((sx * sy + HALF_Q30) >>> 30);
  endtask

  function automatic logic [95:0] predict_point(input logic [95:0] pt);
    longint dx, dy, dz, tw, tx, ty, tz, rx, ry, rz;
    logic [31:0] ox, oy, oz;
    dx = longint'($signed(pt[31:0]))  - center_x;
    dy = longint'($signed(pt[63:32])) - center_y;
    dz = longint'($signed(pt[95:64])) - center_z;
    tw = -qmul(rot_x, dx) - qmul(rot_y, dy) - qmul(rot_z, dz);
    tx =  qmul(rot_w, dx) + qmul(rot_y, dz) - qmul(rot_z, dy);
    ty =  qmul(rot_w, dy) - qmul(rot_x, dz) + qmul(rot_z, dx);
    tz =  qmul(rot_w, dz) + qmul(rot_x, dy) - qmul(rot_y, dx);
    rx = -qmul(rot_x, tw) + qmul(rot_w, tx) - qmul(rot_z, ty) + qmul(rot_y, tz);
    ry = -qmul(rot_y, tw) + qmul(rot_z, tx) + qmul(rot_w, ty) - qmul(rot_x, tz);
    rz = -qmul(rot_z, tw) - qmul(rot_y, tx) + qmul(rot_x, ty) + qmul(rot_w, tz);
    ox = 32'(clamp32(rx + center_x));
    oy = 32'(clamp32(ry + center_y));
    oz = 32'(clamp32(rz + center_z));
    return {oz, oy, ox};
  endfunction

  assign pending_o = expected_points.size();

  // track configuration, queue predictions, check results
  always @(posedge clk_i or negedge rst_ni) begin
    logic [95:0] exp_pt;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      center_x = 0; center_y = 0; center_z = 0;
      ang_x = '0; ang_y = '0;
      rot_w = 64'sd1073741824; rot_x = 0; rot_y = 0; rot_z = 0;
      expected_points.delete();
      err_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point out: %h", m_axis_tdata);
          errs++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (exp_pt[31:0] !== m_axis_tdata[31:0]) begin
            $error("out_x expected %0d got %0d", $signed(exp_pt[31:0]),
                   $signed(m_axis_tdata[31:0]));
            errs++;
          end
          if (exp_pt[63:32] !== m_axis_tdata[63:32]) begin
            $error("out_y expected %0d got %0d", $signed(exp_pt[63:32]),
                   $signed(m_axis_tdata[63:32]));
            errs++;
          end
          if (exp_pt[95:64] !== m_axis_tdata[95:64]) begin
            $error("out_z expected %0d got %0d", $signed(exp_pt[95:64]),
                   $signed(m_axis_tdata[95:64]));
            errs++;
          end
        end
      end
      if (errs != 0)
        err_count_o <= err_count_o + errs;
      if (s_axis_tvalid && s_axis_tready)
        expected_points.push_back(predict_point(s_axis_tdata));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegCenterX: center_x = longint'($signed(cfg_wdata_i));
          RegCenterY: center_y = longint'($signed(cfg_wdata_i));
          RegCenterZ: center_z = longint'($signed(cfg_wdata_i));
          RegAngleX: begin
            ang_x = cfg_wdata_i[AngleW-1:0];
            rebuild_quat();
          end
          RegAngleY: begin
            ang_y = cfg_wdata_i[AngleW-1:0];
            rebuild_quat();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives points and configuration into the quaternion point rotator with
// random gaps and output stalls; the checker predicts and compares every
// rotated point. Directed corner points first, then random phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CfgIdxW-1:0] RegUnused5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnused7 = 3'd7;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [95:0] s_axis_tdata;  // in_x, in_y, in_z
  logic [95:0] m_axis_tdata;  // out_x, out_y, out_z
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_addr_i;
  logic [31:0] cfg_wdata_i;
  int err_count, pending;
  int idle_cycles;
  bit quiet;   // no gaps or stalls while set

  quaternion_point_rotator dut (.*);

  qpr_checker u_checker (.*, .err_count_o(err_count), .pending_o(pending));

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // watchdog: cycles with no item, result or write
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // output side: random stall before each result
  initial begin
    int stall;
    bit seen;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen = m_axis_tvalid;
        @(posedge clk_i);
      end while (!seen);
    end
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int gap;
    bit rdy;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // hold the stream until every result is back, then cover any CORDIC run
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord(input int mode, input logic [31:0] base);
    case (mode)
      0: return $urandom();
      1: return base + 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 32'h7fff;
      1: return 32'hffff8000;
      2: return 32'($signed(16'($urandom_range(12866, 12871))));
      3: return 32'($signed(-16'($urandom_range(12866, 12871))));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] cx, cy, cz;
    int mode;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= RegCenterX;
    cfg_wdata_i   <= '0;
    quiet         = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity rotation straight from reset
    send_point(32'h7fffffff, 32'h80000000, 32'h0);
    send_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_point(32'h00010000, 32'hffff0000, 32'h00000001);
    drain();

    // center writes alone leave the identity; extreme center saturates
    write_reg(RegCenterX, 32'h80000000);
    write_reg(RegCenterY, 32'h7fffffff);
    write_reg(RegCenterZ, 32'h00010000);
    write_reg(RegUnused5, 32'hffffffff);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h0, 32'h0, 32'h80000000);
    drain();

    // largest angles, both signs, and across the half-pi fold
    write_reg(RegAngleX, 32'h7fff);
    write_reg(RegAngleY, 32'hffff8000);
    drain();
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'h00010000, 32'h00020000, 32'h00030000);
    drain();
    write_reg(RegCenterX, 32'h0);
    write_reg(RegCenterY, 32'h0);
    write_reg(RegCenterZ, 32'h0);
    write_reg(RegAngleX, 32'd12868);
    write_reg(RegAngleY, 32'd12869);
    drain();
    send_point(32'h00010000, 32'h00010000, 32'h00010000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();
    write_reg(RegAngleX, 32'hffffcd3c);   // -12996
    write_reg(RegAngleY, 32'hffffcd3b);   // -12997
    write_reg(RegUnused7, 32'h12345678);
    drain();
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h00010000, 32'hffff0000, 32'h00008000);
    drain();
    // zero angles after a write use the CORDIC values, not the identity
    write_reg(RegAngleX, 32'h0);
    write_reg(RegAngleY, 32'h0);
    drain();
    send_point(32'h12345678, 32'h87654321, 32'h7fffffff);
    send_point(32'h80000000, 32'h00000001, 32'hffffffff);
    drain();

    // random phases: new center and angles, then a burst of points
    for (int ph = 0; ph < 8; ph++) begin
      cx = (ph == 1) ? 32'h7fffffff : (ph == 2) ? 32'h80000000 :
           (ph % 3 == 0) ? 32'h0 : $urandom();
      cy = (ph == 2) ? 32'h7fffffff : $urandom();
      cz = (ph == 1) ? 32'h80000000 : $urandom_range(0, 65535) << 8;
      write_reg(RegCenterX, cx);
      write_reg(RegCenterY, cy);
      write_reg(RegCenterZ, cz);
      write_reg(RegAngleX, pick_angle());
      write_reg(RegAngleY, pick_angle());
      drain();
      quiet = (ph % 4 == 3);
      for (int n = 0; n < 120; n++) begin
        mode = $urandom_range(0, 9);
        mode = (mode < 5) ? 0 : (mode < 8) ? 1 : 2;
        send_point(pick_coord(mode, cx), pick_coord(mode, cy), pick_coord(mode, cz));
      end
      quiet = 0;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/qpr_pkg.sv
design/qpr_cordic.sv
design/qpr_quat_gen.sv
design/qpr_rot_pipe.sv
design/quaternion_point_rotator.sv
verif/qpr_checker.sv
verif/testbench.sv
